// ===== rtl/core/tpms_pkg.sv =====
`timescale 1ns / 1ps

package tpms_pkg;

	localparam int unsigned DUTY_W = 8;
	localparam int unsigned TICK_W = 16;
	localparam int unsigned OVF_W = 4;
	localparam int unsigned TIME_W = 16;
	localparam int unsigned VEL_W = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [DUTY_W-1:0] POUR_DUTY_RST = 8'd160;
	localparam logic [DUTY_W-1:0] REVERSE_DUTY_RST = 8'd200;
	localparam logic [TICK_W-1:0] REVERSE_TICKS_RST = 16'h056E;
	localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd254;
	localparam logic [DUTY_W-1:0] DUTY_BAD = 8'd255;
	localparam logic signed [VEL_W-1:0] VEL_MAX = 16'sd254;
	localparam logic signed [VEL_W-1:0] VEL_MIN = -16'sd254;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_POUR = 2'd1,
		CMD_STOP = 2'd2,
		CMD_VEL  = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POUR_DUTY     = 2'd0,
		REG_REVERSE_DUTY  = 2'd1,
		REG_REVERSE_TICKS = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [DUTY_W-1:0] pour_duty;
		logic [DUTY_W-1:0] reverse_duty;
		logic [TICK_W-1:0] reverse_ticks;
	} cfg_t;

	typedef struct packed {
		logic [TICK_W-1:0] tick_count;
		logic [OVF_W-1:0]  overflows_left;
		logic              running;
		logic              reverse;
		logic [DUTY_W-1:0] duty;
		logic              direction;
		logic              done;
	} state_t;

endpackage

// ===== rtl/core/timed_pour_motor_sequencer.sv =====
`timescale 1ns / 1ps

// Timed pour motor sequencer.
// Input channel (in_valid/in_ready) carries one command per transfer: a timer
// tick, a pour start with pour_time, a stop, or a direct signed velocity.
// Output channel (out_valid/out_ready) returns exactly one result per command:
// the motor duty, direction, done line and timer flags after that command.
// Commands land in an input register; the next-state logic then updates the
// state register, which also serves as the result register.
// Throughput is one command per cycle while the receiver takes results; the
// single state update per cycle sets that rate. When the receiver stalls, the
// pending result holds and one more command is kept in the input register;
// in_ready drops only when both are occupied. Configuration writes
// (cfg_valid/cfg_ready, always ready) take effect on the next cycle; the user
// is to issue them while no command is in flight; the block does not enforce it.
// Reset clears the motor state to zero and loads the register defaults:
// pour duty 160, reverse duty 200, reverse ticks 1390. No result is pending.
module timed_pour_motor_sequencer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            cmd,
	input  logic [tpms_pkg::TIME_W-1:0]           pour_time,
	input  logic signed [tpms_pkg::VEL_W-1:0]     velocity,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [tpms_pkg::DUTY_W-1:0]           duty,
	output logic                                  direction,
	output logic                                  done_line,
	output logic                                  timer_running,
	output logic                                  in_reverse,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [tpms_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tpms_pkg::CFG_DATA_W-1:0]       cfg_data
);

	logic valid_s1;
	tpms_pkg::cmd_t cmd_s1;
	logic [tpms_pkg::TIME_W-1:0] pour_time_s1;
	logic signed [tpms_pkg::VEL_W-1:0] velocity_s1;

	tpms_pkg::cfg_t cfg;
	tpms_pkg::state_t state_q;
	tpms_pkg::state_t state_nxt;
	logic out_valid_q;
	logic advance;

	assign cfg_ready = 1'b1;

	tpms_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The result register frees up when it is empty or its transfer completes.
	assign advance = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= tpms_pkg::cmd_t'(cmd);
			pour_time_s1 <= pour_time;
			velocity_s1 <= velocity;
		end
	end

	tpms_step u_step (
		.cur       (state_q),
		.cfg       (cfg),
		.cmd       (cmd_s1),
		.pour_time (pour_time_s1),
		.velocity  (velocity_s1),
		.nxt       (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			out_valid_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign duty = state_q.duty;
	assign direction = state_q.direction;
	assign done_line = state_q.done;
	assign timer_running = state_q.running;
	assign in_reverse = state_q.reverse;

endmodule

// ===== rtl/core/tpms_cfg.sv =====
`timescale 1ns / 1ps

module tpms_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [tpms_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [tpms_pkg::CFG_DATA_W-1:0]     wr_data,
	output tpms_pkg::cfg_t                      cfg
);

	tpms_pkg::cfg_t cfg_q;
	logic [tpms_pkg::DUTY_W-1:0] wr_duty;
	logic duty_ok;

	assign wr_duty = wr_data[tpms_pkg::DUTY_W-1:0];
	// Duty writes of 0 or 255 leave the register as it was.
	assign duty_ok = (wr_duty != '0) && (wr_duty != tpms_pkg::DUTY_BAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pour_duty <= tpms_pkg::POUR_DUTY_RST;
			cfg_q.reverse_duty <= tpms_pkg::REVERSE_DUTY_RST;
			cfg_q.reverse_ticks <= tpms_pkg::REVERSE_TICKS_RST;
		end else if (wr_en) begin
			unique case (tpms_pkg::cfg_reg_t'(wr_index))
				tpms_pkg::REG_POUR_DUTY: begin
					if (duty_ok) cfg_q.pour_duty <= wr_duty;
				end
				tpms_pkg::REG_REVERSE_DUTY: begin
					if (duty_ok) cfg_q.reverse_duty <= wr_duty;
				end
				tpms_pkg::REG_REVERSE_TICKS: begin
					cfg_q.reverse_ticks <= wr_data[tpms_pkg::TICK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/tpms_step.sv =====
`timescale 1ns / 1ps

module tpms_step (
	input  tpms_pkg::state_t                     cur,
	input  tpms_pkg::cfg_t                       cfg,
	input  tpms_pkg::cmd_t                       cmd,
	input  logic [tpms_pkg::TIME_W-1:0]          pour_time,
	input  logic signed [tpms_pkg::VEL_W-1:0]    velocity,
	output tpms_pkg::state_t                     nxt
);

	logic [tpms_pkg::TICK_W-1:0] tick_inc;
	logic signed [tpms_pkg::VEL_W-1:0] vel_neg;
	logic [tpms_pkg::DUTY_W-1:0] vel_mag;
	logic vel_dir;

	assign tick_inc = cur.tick_count + 1'b1;
	assign vel_neg = -velocity;

	always_comb begin
		if (velocity > tpms_pkg::VEL_MAX) begin
			vel_mag = tpms_pkg::DUTY_MAX;
			vel_dir = 1'b1;
		end else if (velocity < tpms_pkg::VEL_MIN) begin
			vel_mag = tpms_pkg::DUTY_MAX;
			vel_dir = 1'b0;
		end else if (!velocity[tpms_pkg::VEL_W-1]) begin
			vel_mag = velocity[tpms_pkg::DUTY_W-1:0];
			vel_dir = 1'b1;
		end else begin
			vel_mag = vel_neg[tpms_pkg::DUTY_W-1:0];
			vel_dir = 1'b0;
		end
	end

	always_comb begin
		nxt = cur;
		unique case (cmd)
			tpms_pkg::CMD_TICK: begin
				if (cur.running) begin
					nxt.tick_count = tick_inc;
					if (tick_inc == '0) begin
						priority if (cur.overflows_left != '0) begin
							nxt.overflows_left = cur.overflows_left - 1'b1;
						end else if (cur.reverse) begin
							nxt.running = 1'b0;
							nxt.reverse = 1'b0;
							nxt.duty = '0;
							nxt.direction = 1'b1;
							nxt.done = 1'b1;
						end else begin
							// Anti-drip phase: run backward for reverse_ticks + 1 ticks.
							nxt.duty = cfg.reverse_duty;
							nxt.direction = 1'b0;
							nxt.tick_count = ~cfg.reverse_ticks;
							nxt.reverse = 1'b1;
						end
					end
				end
			end
			tpms_pkg::CMD_POUR: begin
				// The reverse flag is intentionally left as it was.
				nxt.done = 1'b0;
				nxt.duty = cfg.pour_duty;
				nxt.direction = 1'b1;
				nxt.overflows_left = pour_time[tpms_pkg::TIME_W-1 -: tpms_pkg::OVF_W];
				nxt.tick_count = ~{pour_time[tpms_pkg::TICK_W-5:0], 4'b0000};
				nxt.running = 1'b1;
			end
			tpms_pkg::CMD_STOP: begin
				nxt.running = 1'b0;
				nxt.reverse = 1'b0;
				nxt.duty = '0;
				nxt.direction = 1'b1;
				nxt.done = 1'b1;
			end
			tpms_pkg::CMD_VEL: begin
				nxt.duty = vel_mag;
				nxt.direction = vel_dir;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/core/tpms_checker.sv =====
`timescale 1ns / 1ps

module tpms_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [tpms_pkg::DUTY_W-1:0]     duty,
	input logic                            direction,
	input logic                            done_line,
	input logic                            timer_running,
	input logic                            in_reverse
);

	// A stalled result keeps its contents until the transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(duty) && $stable(direction)
			&& $stable(done_line) && $stable(timer_running) && $stable(in_reverse))
		else $error("stalled result changed");

	// The reverse phase only exists while the timer runs.
	a_rev_running: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_reverse |-> timer_running)
		else $error("reverse flag set with timer stopped");

	// The done line and a running timer never show together.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_line |-> !timer_running)
		else $error("done line high while timer runs");

	// Duty is always clamped below 255.
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> duty != tpms_pkg::DUTY_BAD)
		else $error("duty out of range");

	// With the input register and result register both free, in_ready is high.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !$past(in_valid && in_ready) |-> in_ready)
		else $error("input stalled with empty pipeline");

endmodule

bind timed_pour_motor_sequencer tpms_checker u_tpms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.duty          (duty),
	.direction     (direction),
	.done_line     (done_line),
	.timer_running (timer_running),
	.in_reverse    (in_reverse)
);

// ===== tb/timed_pour_motor_sequencer_tb.sv =====
`timescale 1ns / 1ps

module timed_pour_motor_sequencer_tb;
	import tpms_pkg::*;

	localparam int RANDOM_ITEMS = 1780;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int STUCK_LIMIT = 3000;
	localparam int OVERFLOW_TICKS = 40;
	// Index 3 maps to no register; a write there must leave every setting alone.
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              direction;
		logic              done;
		logic              running;
		logic              reverse;
	} motor_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	cmd_t cmd = CMD_TICK;
	logic [TIME_W-1:0] pour_time = '0;
	logic signed [VEL_W-1:0] velocity = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [DUTY_W-1:0] duty;
	logic direction;
	logic done_line;
	logic timer_running;
	logic in_reverse;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	state_t motor_st;
	cfg_t motor_cfg;
	motor_out_t expected_motor_q[$];

	bit gaps_enabled = 1'b1;
	bit hold_request = 1'b0;
	int items_sent = 0;
	int results_seen = 0;
	int reg_writes = 0;
	int errors = 0;
	int stuck_cycles = 0;

	timed_pour_motor_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.pour_time(pour_time),
		.velocity(velocity),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.duty(duty),
		.direction(direction),
		.done_line(done_line),
		.timer_running(timer_running),
		.in_reverse(in_reverse),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic void set_motor_speed(input int v);
		int mag;
		if (v > int'(VEL_MAX)) v = int'(VEL_MAX);
		if (v < int'(VEL_MIN)) v = int'(VEL_MIN);
		mag = (v < 0) ? -v : v;
		motor_st.direction = (v >= 0);
		motor_st.duty = mag[DUTY_W-1:0];
	endfunction

	function automatic void halt_motor_model();
		motor_st.running = 1'b0;
		set_motor_speed(0);
		motor_st.done = 1'b1;
		motor_st.reverse = 1'b0;
	endfunction

	// Advances the motor state by one command and returns what the outputs show after it.
	function automatic motor_out_t advance_motor(input cmd_t c, input logic [TIME_W-1:0] pt,
			input logic signed [VEL_W-1:0] v);
		motor_out_t r;
		case (c)
			CMD_TICK: begin
				if (motor_st.running) begin
					motor_st.tick_count = motor_st.tick_count + 1'b1;
					if (motor_st.tick_count == '0) begin
						if (motor_st.overflows_left != '0) begin
							motor_st.overflows_left = motor_st.overflows_left - 1'b1;
						end else if (motor_st.reverse) begin
							halt_motor_model();
						end else begin
							set_motor_speed(-int'(motor_cfg.reverse_duty));
							motor_st.tick_count = 16'hFFFF - motor_cfg.reverse_ticks;
							motor_st.reverse = 1'b1;
						end
					end
				end
			end
			CMD_POUR: begin
				// The reverse flag survives a new pour on purpose.
				motor_st.done = 1'b0;
				set_motor_speed(int'(motor_cfg.pour_duty));
				motor_st.overflows_left = pt[15:12];
				motor_st.tick_count = 16'hFFFF - {pt[11:0], 4'b0000};
				motor_st.running = 1'b1;
			end
			CMD_STOP: halt_motor_model();
			default: set_motor_speed(int'(v));
		endcase
		r.duty = motor_st.duty;
		r.direction = motor_st.direction;
		r.done = motor_st.done;
		r.running = motor_st.running;
		r.reverse = motor_st.reverse;
		return r;
	endfunction

	function automatic logic [VEL_W-1:0] random_velocity();
		int r;
		if ($urandom_range(0, 1) == 0) r = $urandom_range(0, 65535);
		else r = int'($urandom_range(0, 600)) - 300;
		return r[VEL_W-1:0];
	endfunction

	task automatic send_item(input cmd_t c, input logic [TIME_W-1:0] pt,
			input logic [VEL_W-1:0] v);
		int gap;
		gap = gaps_enabled ? $urandom_range(0, 14) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		pour_time <= pt;
		velocity <= v;
		do @(posedge clk); while (!(in_valid && in_ready));
		expected_motor_q.push_back(advance_motor(c, pt, v));
		items_sent++;
	endtask

	task automatic send_noise();
		send_item(cmd_t'($urandom_range(0, 3)), TIME_W'($urandom_range(0, 65535)),
			random_velocity());
	endtask

	task automatic send_tick();
		send_item(CMD_TICK, TIME_W'($urandom_range(0, 65535)), random_velocity());
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_motor_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		reg_writes++;
		case (idx)
			REG_POUR_DUTY:
				if (data[7:0] != '0 && data[7:0] != DUTY_BAD) motor_cfg.pour_duty = data[7:0];
			REG_REVERSE_DUTY:
				if (data[7:0] != '0 && data[7:0] != DUTY_BAD) motor_cfg.reverse_duty = data[7:0];
			REG_REVERSE_TICKS: motor_cfg.reverse_ticks = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] random_duty_word();
		logic [CFG_DATA_W-1:0] w;
		w = CFG_DATA_W'($urandom_range(0, 65535));
		case ($urandom_range(0, 9))
			0: w[7:0] = '0;
			1: w[7:0] = DUTY_BAD;
			2: w = 16'd1;
			3: w = {8'h00, DUTY_MAX};
			default: ;
		endcase
		return w;
	endfunction

	task automatic load_random_config();
		logic [CFG_DATA_W-1:0] ticks;
		case ($urandom_range(0, 9))
			0: ticks = '0;
			1: ticks = 16'hFFFF;
			2: ticks = CFG_DATA_W'($urandom_range(0, 65535));
			default: ticks = CFG_DATA_W'($urandom_range(0, 40));
		endcase
		write_reg(REG_POUR_DUTY, random_duty_word());
		write_reg(REG_REVERSE_DUTY, random_duty_word());
		write_reg(REG_REVERSE_TICKS, ticks);
	endtask

	// A pour followed by enough ticks to usually reach the reverse phase and the
	// stop, with a stray stop, re-pour or velocity command now and then.
	task automatic run_pour_sequence();
		logic [TIME_W-1:0] pt;
		int needed;
		int n;
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) pt = TIME_W'($urandom_range(0, 3));
		else if (r < 85) pt = TIME_W'($urandom_range(4, 15));
		else pt = TIME_W'($urandom_range(0, 65535));
		send_item(CMD_POUR, pt, random_velocity());
		needed = int'(pt[11:0]) * 16 + int'(motor_cfg.reverse_ticks) + 2;
		if (pt[15:12] != '0 || needed > 400) n = $urandom_range(0, 60);
		else n = $urandom_range(needed / 2, needed + 5);
		repeat (n) begin
			r = $urandom_range(0, 199);
			if (r == 0)
				send_item(CMD_STOP, TIME_W'($urandom_range(0, 65535)), random_velocity());
			else if (r == 1)
				send_item(CMD_POUR, TIME_W'($urandom_range(0, 3)), random_velocity());
			else if (r < 5)
				send_item(CMD_VEL, TIME_W'($urandom_range(0, 65535)), random_velocity());
			else
				send_tick();
		end
		if ($urandom_range(0, 2) == 0)
			send_item(CMD_STOP, TIME_W'($urandom_range(0, 65535)), random_velocity());
	endtask

	task automatic test_idle_and_velocity();
		send_tick();
		send_item(CMD_VEL, 16'hFFFF, 16'h7FFF);
		send_item(CMD_VEL, 16'h0000, 16'h8000);
		send_item(CMD_VEL, 16'h1234, 16'd255);
		send_item(CMD_VEL, 16'h0000, -16'sd255);
		send_item(CMD_VEL, 16'h0000, 16'd254);
		send_item(CMD_VEL, 16'h0000, -16'sd254);
		send_item(CMD_VEL, 16'h0000, 16'd0);
		send_item(CMD_VEL, 16'h0000, -16'sd1);
		send_item(CMD_VEL, 16'h0000, 16'd1);
	endtask

	task automatic test_register_writes();
		wait_drained();
		write_reg(REG_POUR_DUTY, 16'h0000);
		write_reg(REG_POUR_DUTY, 16'hFFFF);
		write_reg(REG_POUR_DUTY, 16'd1);
		write_reg(REG_REVERSE_DUTY, 16'h0000);
		write_reg(REG_REVERSE_DUTY, 16'h00FF);
		write_reg(REG_REVERSE_DUTY, {8'h00, DUTY_MAX});
		write_reg(REG_REVERSE_TICKS, 16'h0000);
		write_reg(REG_NONE, 16'hFFFF);
		send_item(CMD_POUR, 16'h0000, 16'h0000);
		send_tick();
		send_tick();
		wait_drained();
		write_reg(REG_POUR_DUTY, {8'hC3, DUTY_MAX});
		write_reg(REG_REVERSE_DUTY, 16'hAB01);
		write_reg(REG_REVERSE_TICKS, 16'hFFFF);
		send_item(CMD_POUR, 16'h0000, 16'h0000);
		repeat (4) send_tick();
		send_item(CMD_STOP, 16'h0000, 16'h0000);
	endtask

	task automatic test_pour_phases();
		wait_drained();
		write_reg(REG_POUR_DUTY, {8'h00, POUR_DUTY_RST});
		write_reg(REG_REVERSE_DUTY, {8'h00, REVERSE_DUTY_RST});
		write_reg(REG_REVERSE_TICKS, 16'd2);
		send_item(CMD_STOP, 16'h0000, 16'h0000);
		send_item(CMD_POUR, 16'h0000, 16'h0000);
		repeat (5) send_tick();
		send_item(CMD_POUR, 16'hFFFF, 16'h0000);
		send_item(CMD_VEL, 16'h0000, -16'sd100);
		send_tick();
		send_item(CMD_STOP, 16'h0000, 16'h0000);
		// Pouring again during the reverse phase keeps the flag, so the next wrap stops.
		send_item(CMD_POUR, 16'h0000, 16'h0000);
		send_tick();
		send_item(CMD_POUR, 16'h0000, 16'h0000);
		send_tick();
		send_tick();
	endtask

	task automatic test_backpressure();
		wait_drained();
		gaps_enabled = 1'b0;
		hold_request = 1'b1;
		repeat (24) send_noise();
		// The sender now waits until the output side has taken every result.
		wait_drained();
		repeat (10) send_noise();
		gaps_enabled = 1'b1;
	endtask

	task automatic test_random_traffic();
		int base;
		int seq;
		base = items_sent;
		seq = 0;
		while (items_sent - base < RANDOM_ITEMS) begin
			if (seq % 4 == 0) begin
				wait_drained();
				load_random_config();
			end
			gaps_enabled = ($urandom_range(0, 4) != 0);
			if ($urandom_range(0, 9) < 8) run_pour_sequence();
			else repeat ($urandom_range(1, 6)) send_noise();
			seq++;
		end
		gaps_enabled = 1'b1;
	endtask

	// With one overflow left, the first tick wraps the counter and only uses up the
	// overflow count, so the pour keeps running with no reverse phase.
	task automatic test_overflow_wrap();
		wait_drained();
		write_reg(REG_REVERSE_TICKS, 16'd3);
		gaps_enabled = 1'b0;
		send_item(CMD_POUR, 16'h1000, random_velocity());
		repeat (OVERFLOW_TICKS) send_tick();
		send_item(CMD_STOP, 16'h0000, 16'h0000);
		gaps_enabled = 1'b1;
	endtask

	task automatic report_field(input string field, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		motor_out_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_motor_q.size() == 0) begin
				$display("%0t: result transfer with nothing expected, actual duty %0d", $time, duty);
				errors++;
			end else begin
				want = expected_motor_q.pop_front();
				report_field("duty", int'(want.duty), int'(duty));
				report_field("direction", int'(want.direction), int'(direction));
				report_field("done_line", int'(want.done), int'(done_line));
				report_field("timer_running", int'(want.running), int'(timer_running));
				report_field("in_reverse", int'(want.reverse), int'(in_reverse));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin : output_side
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = gaps_enabled ? $urandom_range(0, 14) : 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	initial begin
		motor_st = '0;
		motor_cfg.pour_duty = POUR_DUTY_RST;
		motor_cfg.reverse_duty = REVERSE_DUTY_RST;
		motor_cfg.reverse_ticks = REVERSE_TICKS_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_and_velocity();
		test_register_writes();
		test_pour_phases();
		test_backpressure();
		test_random_traffic();
		test_overflow_wrap();
		wait_drained();
		$display("Sent %0d commands, checked %0d results, made %0d register writes.",
			items_sent, results_seen, reg_writes);
		$display("Covered pours, reverse phases, stops, velocity clamping, %s",
			"a counter wrap with an overflow left and a long output stall.");
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
